/* rtl/core/tfq_pkg.sv */
// Shared types, codes and default sizes for the grouped team queue.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package tfq_pkg;

  localparam int ID_W       = 10;
  localparam int TEAM_IN_W  = 4;
  localparam int TEAM_MAX_W = 8;

  localparam int NUM_TEAMS_DEF    = 16;
  localparam int ID_SPACE_DEF     = 1024;
  localparam int BUFFER_SLOTS_DEF = 256;

  localparam logic [1:0] FN_ASSIGN = 2'd0;
  localparam logic [1:0] FN_ENQ    = 2'd1;
  localparam logic [1:0] FN_DEQ    = 2'd2;
  localparam logic [1:0] FN_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]           func;
    logic [ID_W-1:0]      element_id;
    logic [TEAM_IN_W-1:0] team_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] out_element;
    logic            out_valid;
    logic [1:0]      status;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [1:0]            op;
    logic [ID_W-1:0]       elem;
    logic [TEAM_MAX_W-1:0] team;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/tfq_front.sv */
// Front end: accepts requests, owns the membership table and its clearing sweep.
// Depends on tfq_pkg.
`default_nettype none

module tfq_front
  import tfq_pkg::*;
#(
  parameter int NUM_TEAMS = NUM_TEAMS_DEF,
  parameter int ID_SPACE  = ID_SPACE_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd_data
);

  localparam int MT_DEPTH = (ID_SPACE < (1 << ID_W)) ? ID_SPACE : (1 << ID_W);
  localparam int MT_AW    = $clog2(MT_DEPTH);
  localparam int TW       = (NUM_TEAMS > 1) ? $clog2(NUM_TEAMS) : 1;

  logic [TW-1:0] mt_mem [MT_DEPTH];
  logic [TW-1:0] mt_rd_r;

  logic            stg_v_r;
  in_item_t        stg_r;
  logic            sweep_r;
  logic [MT_AW-1:0] sweep_cnt_r;

  logic             accept;
  logic             push;
  logic             mt_we;
  logic [MT_AW-1:0] mt_wa;
  logic [TW-1:0]    mt_wd;
  logic             in_range_in;
  logic             in_range_stg;
  logic             stg_clear;

  assign in_range_in  = 32'(in_data.element_id) < ID_SPACE;
  assign in_range_stg = 32'(stg_r.element_id) < ID_SPACE;
  assign stg_clear    = stg_v_r && (stg_r.func == FN_CLEAR);
  assign push         = stg_v_r && cmd_ready;
  assign in_ready     = !sweep_r && !stg_clear && (!stg_v_r || cmd_ready);
  assign accept       = in_valid && in_ready;

  assign cmd_valid     = stg_v_r;
  assign cmd_data.op   = stg_r.func;
  assign cmd_data.elem = stg_r.element_id;
  assign cmd_data.team = ((stg_r.func == FN_ENQ) && in_range_stg) ?
                         TEAM_MAX_W'(mt_rd_r) : '0;

  always_comb begin
    mt_we = 1'b0;
    mt_wa = in_data.element_id[MT_AW-1:0];
    mt_wd = TW'(in_data.team_id);
    if (sweep_r) begin
      mt_we = 1'b1;
      mt_wa = sweep_cnt_r;
      mt_wd = '0;
    end else if (accept && (in_data.func == FN_ASSIGN) && in_range_in &&
                 (32'(in_data.team_id) < NUM_TEAMS)) begin
      mt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mt_we) begin
      mt_mem[mt_wa] <= mt_wd;
    end
    if (accept) begin
      mt_rd_r <= mt_mem[in_data.element_id[MT_AW-1:0]];
      stg_r   <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r     <= 1'b0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else begin
      if (accept) begin
        stg_v_r <= 1'b1;
      end else if (push) begin
        stg_v_r <= 1'b0;
      end
      // start zeroing the table once the clear has been handed on
      if (push && stg_clear) begin
        sweep_r     <= 1'b1;
        sweep_cnt_r <= '0;
      end else if (sweep_r) begin
        if (sweep_cnt_r == MT_AW'(MT_DEPTH - 1)) begin
          sweep_r <= 1'b0;
        end
        sweep_cnt_r <= sweep_cnt_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tfq_cmdq.sv */
// Two-entry request queue between front and back.
// Depends on tfq_pkg.
`default_nettype none

module tfq_cmdq
  import tfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire cmd_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_data
);

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = ent_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tfq_back.sv */
// Back end: linked-list slot pool, per-team head/tail, team order queue, result register.
// Depends on tfq_pkg.
`default_nettype none

module tfq_back
  import tfq_pkg::*;
#(
  parameter int NUM_TEAMS    = NUM_TEAMS_DEF,
  parameter int BUFFER_SLOTS = BUFFER_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd_data,
  output logic      res_valid,
  input  wire logic res_ready,
  output out_item_t res_data
);

  localparam int SW = $clog2(BUFFER_SLOTS);
  localparam int TW = (NUM_TEAMS > 1) ? $clog2(NUM_TEAMS) : 1;
  localparam int NT = NUM_TEAMS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENQ  = 2'd1;
  localparam logic [1:0] S_DEQ  = 2'd2;

  // memories
  logic [SW-1:0]   fl_mem [BUFFER_SLOTS];
  logic [ID_W-1:0] se_mem [BUFFER_SLOTS];
  logic [SW-1:0]   sn_mem [BUFFER_SLOTS];
  logic [SW-1:0]   fl_rd_r;
  logic [ID_W-1:0] se_rd_r;
  logic [SW-1:0]   sn_rd_r;

  // per-team registers
  logic [SW-1:0] head_r  [NT];
  logic [SW-1:0] tail_r  [NT];
  logic [TW-1:0] order_r [NT];
  logic [NT-1:0] nonempty_r, nonempty_nxt;

  logic [1:0]      state_r, state_nxt;
  logic [SW:0]     fc_r, fc_nxt;
  logic [SW:0]     low_r, low_nxt;
  logic [SW-1:0]   k_r, k_nxt;
  logic            fresh_r, fresh_nxt;
  logic [ID_W-1:0] elem_r, elem_nxt;
  logic [TW-1:0]   team_r, team_nxt;
  logic            last_r, last_nxt;
  logic [TW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [TW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [TW:0]     ocnt_r, ocnt_nxt;
  logic            res_v_r, res_v_nxt;
  out_item_t       res_r, res_nxt;

  logic            res_free;
  logic [TW-1:0]   cteam;
  logic [TW-1:0]   oteam;
  logic [SW-1:0]   hslot;
  logic [SW-1:0]   eslot;

  logic            fl_re, fl_we;
  logic [SW-1:0]   fl_ra, fl_wa, fl_wd;
  logic            sl_re;
  logic [SW-1:0]   sl_ra;
  logic            se_we, sn_we;
  logic [SW-1:0]   se_wa, sn_wa, sn_wd;
  logic            head_we, tail_we, order_we;
  logic [TW-1:0]   head_wa, tail_wa;
  logic [SW-1:0]   head_wd, tail_wd;

  assign res_free  = !res_v_r || res_ready;
  assign cmd_ready = (state_r == S_IDLE) && res_free;
  assign res_valid = res_v_r;
  assign res_data  = res_r;

  assign cteam = TW'(cmd_data.team);
  assign oteam = order_r[rd_ptr_r];
  assign hslot = head_r[oteam];
  assign eslot = fresh_r ? k_r : fl_rd_r;

  always_comb begin
    state_nxt    = state_r;
    fc_nxt       = fc_r;
    low_nxt      = low_r;
    k_nxt        = k_r;
    fresh_nxt    = fresh_r;
    elem_nxt     = elem_r;
    team_nxt     = team_r;
    last_nxt     = last_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    ocnt_nxt     = ocnt_r;
    nonempty_nxt = nonempty_r;
    res_v_nxt    = res_v_r && !res_ready;
    res_nxt      = res_r;
    fl_re = 1'b0; fl_ra = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0;
    sl_re = 1'b0; sl_ra = hslot;
    se_we = 1'b0; se_wa = eslot;
    sn_we = 1'b0; sn_wa = '0; sn_wd = eslot;
    head_we = 1'b0; head_wa = team_r; head_wd = eslot;
    tail_we = 1'b0; tail_wa = team_r; tail_wd = eslot;
    order_we = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && res_free) begin
          res_v_nxt = 1'b1;
          res_nxt   = '{out_element: '0, out_valid: 1'b0, status: ST_OK};
          case (cmd_data.op)
            FN_ASSIGN: begin
            end
            FN_CLEAR: begin
              fc_nxt       = (SW+1)'(BUFFER_SLOTS);
              low_nxt      = (SW+1)'(BUFFER_SLOTS);
              rd_ptr_nxt   = '0;
              wr_ptr_nxt   = '0;
              ocnt_nxt     = '0;
              nonempty_nxt = '0;
            end
            FN_ENQ: begin
              if (fc_r == '0) begin
                res_nxt.status = ST_FULL;
              end else begin
                // pop the free stack; below the low mark it still holds its index
                res_v_nxt = res_v_r && !res_ready;
                fl_re     = 1'b1;
                fl_ra     = SW'(fc_r - 1'b1);
                k_nxt     = SW'(fc_r - 1'b1);
                fresh_nxt = (fc_r == low_r);
                fc_nxt    = fc_r - 1'b1;
                if (fc_r == low_r) low_nxt = fc_r - 1'b1;
                elem_nxt  = cmd_data.elem;
                team_nxt  = cteam;
                state_nxt = S_ENQ;
              end
            end
            FN_DEQ: begin
              if (ocnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                res_v_nxt = res_v_r && !res_ready;
                sl_re     = 1'b1;
                team_nxt  = oteam;
                if (fc_r < (SW+1)'(BUFFER_SLOTS)) begin
                  fl_we  = 1'b1;
                  fl_wa  = SW'(fc_r);
                  fl_wd  = hslot;
                  fc_nxt = fc_r + 1'b1;
                end
                last_nxt = (hslot == tail_r[oteam]);
                if (hslot == tail_r[oteam]) begin
                  nonempty_nxt[oteam] = 1'b0;
                  rd_ptr_nxt = (rd_ptr_r == TW'(NT - 1)) ? '0 : rd_ptr_r + 1'b1;
                  ocnt_nxt   = ocnt_r - 1'b1;
                end
                state_nxt = S_DEQ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ENQ: begin
        if (res_free) begin
          se_we = 1'b1;
          if (!nonempty_r[team_r]) begin
            nonempty_nxt[team_r] = 1'b1;
            head_we = 1'b1;
            tail_we = 1'b1;
            if (ocnt_r < (TW+1)'(NT)) begin
              order_we   = 1'b1;
              wr_ptr_nxt = (wr_ptr_r == TW'(NT - 1)) ? '0 : wr_ptr_r + 1'b1;
              ocnt_nxt   = ocnt_r + 1'b1;
            end
          end else begin
            // link behind the current tail
            sn_we   = 1'b1;
            sn_wa   = tail_r[team_r];
            tail_we = 1'b1;
          end
          res_v_nxt = 1'b1;
          res_nxt   = '{out_element: '0, out_valid: 1'b0, status: ST_OK};
          state_nxt = S_IDLE;
        end
      end
      S_DEQ: begin
        if (res_free) begin
          if (!last_r) begin
            head_we = 1'b1;
            head_wd = sn_rd_r;
          end
          res_v_nxt = 1'b1;
          res_nxt   = '{out_element: se_rd_r, out_valid: 1'b1, status: ST_OK};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    if (fl_re) fl_rd_r <= fl_mem[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (se_we) se_mem[se_wa] <= elem_r;
    if (sl_re) se_rd_r <= se_mem[sl_ra];
  end

  always_ff @(posedge clk) begin
    if (sn_we) sn_mem[sn_wa] <= sn_wd;
    if (sl_re) sn_rd_r <= sn_mem[sl_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_r[head_wa] <= head_wd;
    if (tail_we) tail_r[tail_wa] <= tail_wd;
    if (order_we) order_r[wr_ptr_r] <= team_r;
    k_r     <= k_nxt;
    fresh_r <= fresh_nxt;
    elem_r  <= elem_nxt;
    team_r  <= team_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fc_r       <= (SW+1)'(BUFFER_SLOTS);
      low_r      <= (SW+1)'(BUFFER_SLOTS);
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      ocnt_r     <= '0;
      nonempty_r <= '0;
      res_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fc_r       <= fc_nxt;
      low_r      <= low_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      ocnt_r     <= ocnt_nxt;
      nonempty_r <= nonempty_nxt;
      res_v_r    <= res_v_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/grouped_team_fifo_top.sv */
// Top level of the grouped team queue: front end, request queue, back end.
// Depends on tfq_pkg, tfq_front, tfq_cmdq, tfq_back.
//
//   channel | ports                          | direction
//   in      | in_valid, in_ready, in_data    | request into the block
//   out     | out_valid, out_ready, out_data | one result per request
//
// Enqueue and dequeue read a memory in S_IDLE (free list or slot memory), then
// update the links in S_ENQ or S_DEQ; assign, clear and error cases finish in
// S_IDLE. The front registers the membership lookup, and the 2-entry queue lets
// front and back overlap.
// After reset and after each clear the membership table is zeroed entry by entry,
// min(ID_SPACE, 1024) entries in all; in_ready stays low meanwhile.
// A stalled result register holds the back end; the queue then holds the front.
`default_nettype none

module grouped_team_fifo_top
  import tfq_pkg::*;
#(
  parameter int NUM_TEAMS    = NUM_TEAMS_DEF,
  parameter int ID_SPACE     = ID_SPACE_DEF,
  parameter int BUFFER_SLOTS = BUFFER_SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic f_valid, f_ready;
  cmd_t f_data;
  logic b_valid, b_ready;
  cmd_t b_data;

  tfq_front #(
    .NUM_TEAMS (NUM_TEAMS),
    .ID_SPACE  (ID_SPACE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  tfq_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  tfq_back #(
    .NUM_TEAMS    (NUM_TEAMS),
    .BUFFER_SLOTS (BUFFER_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_data  (b_data),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/core/tfq_checker.sv */
// Port-level checks for grouped_team_fifo_top, attached by bind.
// Depends on tfq_pkg.
`default_nettype none

module tfq_checker
  import tfq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_sweep: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken during table clear");

  a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_valid |-> out_data.status == ST_OK)
    else $error("element delivered with error status");

  a_no_elem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_valid |-> out_data.out_element == '0)
    else $error("stray element on non-dequeue result");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request dropped or changed while waiting");

endmodule

bind grouped_team_fifo_top tfq_checker u_tfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
